[design/sequential_list_engine_core_defines.svh]
// assertion macros for the list engine datapath
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sle_pkg.sv]
// package: opcodes, status codes, beat layout and controller/datapath link types
package sle_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    localparam int OPCODE_W   = 2;
    localparam int POSITION_W = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 7;
    localparam int LENGTH_W   = 8;

    localparam int S_FIELDS_W = OPCODE_W + POSITION_W + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + VALUE_W + FOUND_W + LENGTH_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic walk;
        logic del_read;
        logic del_cap;
        logic ins_write;
        logic cnt_dec;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       acc_ok;
        logic [1:0] acc_op;
        logic       walk_done;
        logic       out_free;
    } sts_t;

endpackage

[design/sle_datapath.sv]
// datapath: entry memory, walk pointer, count and output beat register
`include "sequential_list_engine_core_defines.svh"
module sle_datapath #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sle_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         m_tready,
    input  sle_pkg::cmd_t                cmd,
    output sle_pkg::sts_t                sts,
    output logic                         m_tvalid,
    output logic [sle_pkg::M_TDATA_W-1:0] m_tdata
);
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    logic [OPCODE_W-1:0]   op_in;
    logic [POSITION_W-1:0] pos_in;
    logic [VALUE_W-1:0]    val_in;
    logic [PW-1:0]         pos_x, cnt_x, idx_w;
    logic                  acc_ok, walk_done, out_free;

    logic [1:0]         op_reg, op_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CW-1:0]      ptr_reg, ptr_next, ptr_inc, ptr_dec;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      found_reg, found_next;
    logic [VALUE_W-1:0] removed_reg, removed_next;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      count_reg, count_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [VALUE_W-1:0] wr_data;

    logic               m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_removed_reg;
    logic [FOUND_W-1:0]  out_found_reg;
    logic [LENGTH_W-1:0] out_length_reg;
    logic [AW+FOUND_W-1:0]  found_ext;
    logic [CW+LENGTH_W-1:0] length_ext;

    assign op_in  = s_tdata[OPCODE_W-1:0];
    assign pos_in = s_tdata[OPCODE_W+POSITION_W-1:OPCODE_W];
    assign val_in = s_tdata[S_FIELDS_W-1:OPCODE_W+POSITION_W];
    assign pos_x  = PW'(pos_in);
    assign cnt_x  = PW'(count_reg);
    assign idx_w  = pos_x - PW'(1);
    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);

    // item check against the current length
    always_comb begin
        case (op_in)
            OP_INSERT: acc_ok = (pos_x != '0) && (pos_x <= cnt_x + PW'(1))
                                && (count_reg != CAP_C);
            OP_DELETE: acc_ok = (pos_x != '0) && (pos_x <= cnt_x);
            OP_LOCATE: acc_ok = 1'b1;
            default:   acc_ok = 1'b0;
        endcase
    end
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        case (op_reg)
            OP_INSERT: walk_done = !pend_reg && (ptr_reg <= CW'(idx_reg));
            OP_DELETE: walk_done = !pend_reg && (ptr_reg >= count_reg);
            default:   walk_done = !pend_reg && ((ptr_reg >= count_reg) || hit_reg);
        endcase
    end

    assign sts = {acc_ok, op_in, walk_done, out_free};

    always_comb begin
        op_next        = op_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        rd_addr        = ptr_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rdata_reg;

        if (cmd.load) begin
            op_next      = op_in;
            idx_next     = idx_w[AW-1:0];
            val_next     = val_in;
            pend_next    = 1'b0;
            hit_next     = 1'b0;
            found_next   = '0;
            removed_next = '0;
            if (!acc_ok) begin
                status_next = STAT_BAD;
            end else if (op_in == OP_LOCATE) begin
                status_next = STAT_MISS;
            end else begin
                status_next = STAT_DONE;
            end
            case (op_in)
                OP_INSERT: ptr_next = count_reg;
                OP_DELETE: ptr_next = pos_x[CW-1:0];
                default:   ptr_next = '0;
            endcase
        end

        if (cmd.del_read) begin
            rd_addr = idx_reg;
        end

        if (cmd.del_cap) begin
            removed_next = rdata_reg;
        end

        if (cmd.walk) begin
            case (op_reg)
                OP_INSERT: begin
                    wr_en = pend_reg;
                    if (ptr_reg > CW'(idx_reg)) begin
                        rd_addr        = ptr_dec[AW-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = ptr_reg[AW-1:0];
                        ptr_next       = ptr_dec;
                    end else begin
                        pend_next = 1'b0;
                    end
                end
                OP_DELETE: begin
                    wr_en = pend_reg;
                    if (ptr_reg < count_reg) begin
                        rd_addr        = ptr_reg[AW-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = ptr_dec[AW-1:0];
                        ptr_next       = ptr_inc;
                    end else begin
                        pend_next = 1'b0;
                    end
                end
                default: begin
                    if ((ptr_reg < count_reg) && !hit_reg) begin
                        rd_addr        = ptr_reg[AW-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = ptr_reg[AW-1:0];
                        ptr_next       = ptr_inc;
                    end else begin
                        pend_next = 1'b0;
                    end
                    if (pend_reg && !hit_reg && (rdata_reg == val_reg)) begin
                        hit_next    = 1'b1;
                        found_next  = pend_addr_reg;
                        status_next = STAT_DONE;
                    end
                end
            endcase
        end

        if (cmd.ins_write) begin
            wr_en      = 1'b1;
            wr_addr    = idx_reg;
            wr_data    = val_reg;
            count_next = count_reg + CW'(1);
        end

        if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
    end

    assign found_ext  = {{FOUND_W{1'b0}}, found_reg};
    assign length_ext = {{LENGTH_W{1'b0}}, count_reg};

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg  <= status_reg;
            out_removed_reg <= removed_reg;
            out_found_reg   <= found_ext[FOUND_W-1:0];
            out_length_reg  <= length_ext[LENGTH_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, out_length_reg, out_found_reg,
                       out_removed_reg, out_status_reg};

    `SLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_C, "list length beyond capacity")
    `SLE_ASSERT_NOW(a_ins_room, cmd.ins_write, count_reg != CAP_C, "insert into full list")
    `SLE_ASSERT_NOW(a_dec_nonempty, cmd.cnt_dec, count_reg != '0, "delete from empty list")
    `SLE_ASSERT_NOW(a_out_free, cmd.out_load, !m_tvalid_reg || m_tready,
                    "output beat overwritten")

endmodule

[design/sle_controller.sv]
// controller: sequences insert, delete and locate walks over the datapath
module sle_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  sle_pkg::sts_t sts,
    output sle_pkg::cmd_t cmd
);
    import sle_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INS_SHIFT = 8'b0000_0010,
        S_INS_WRITE = 8'b0000_0100,
        S_DEL_READ  = 8'b0000_1000,
        S_DEL_CAP   = 8'b0001_0000,
        S_DEL_SHIFT = 8'b0010_0000,
        S_LOC_SCAN  = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (!sts.acc_ok) begin
                        state_next = S_FINISH;
                    end else begin
                        case (sts.acc_op)
                            OP_INSERT: state_next = S_INS_SHIFT;
                            OP_DELETE: state_next = S_DEL_READ;
                            default:   state_next = S_LOC_SCAN;
                        endcase
                    end
                end
            end
            S_INS_SHIFT: begin
                cmd.walk = 1'b1;
                if (sts.walk_done) begin
                    state_next = S_INS_WRITE;
                end
            end
            S_INS_WRITE: begin
                cmd.ins_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_DEL_READ: begin
                cmd.del_read = 1'b1;
                state_next   = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                cmd.del_cap = 1'b1;
                state_next  = S_DEL_SHIFT;
            end
            S_DEL_SHIFT: begin
                cmd.walk = 1'b1;
                if (sts.walk_done) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_LOC_SCAN: begin
                cmd.walk = 1'b1;
                if (sts.walk_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/sequential_list_engine_core.sv]
// top level: ordered list engine with positional insert, delete and locate
// one item at a time; a refused item skips the walk and its result beat is loaded once the output register is free
// insert shifts the tail up then writes the new entry; delete captures the removed entry then
// shifts the tail down; locate compares; the entry memory does one read and one write, one entry per cycle
// the next item is taken the cycle after its result beat is loaded, even while it waits
// aresetn (synchronous) empties the list; entry contents are not cleared
module sequential_list_engine_core #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sle_pkg::S_TDATA_W-1:0] s_tdata,  // opcode, position, value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sle_pkg::M_TDATA_W-1:0] m_tdata   // status, removed_value, found_index, list_length
);
    import sle_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sle_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

[tb/sequential_list_engine_checker.sv]
// list engine checker: mirrors the list from accepted input beats and compares each result beat
`timescale 1ns / 1ps
module sequential_list_engine_checker #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sle_pkg::S_TDATA_W-1:0] s_tdata,  // opcode, position, value
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sle_pkg::M_TDATA_W-1:0] m_tdata,  // status, removed_value, found_index, list_length
    output int                            fail_count,
    output int                            outstanding
);
    import sle_pkg::*;

    localparam int POS_LSB     = OPCODE_W;
    localparam int VAL_LSB     = POS_LSB + POSITION_W;
    localparam int REMOVED_LSB = STATUS_W;
    localparam int FOUND_LSB   = REMOVED_LSB + VALUE_W;
    localparam int LENGTH_LSB  = FOUND_LSB + FOUND_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed_value;
        logic [FOUND_W-1:0]  found_index;
        logic [LENGTH_W-1:0] list_length;
    } list_reply_t;

    logic [VALUE_W-1:0] shadow_entries [CAPACITY];
    int                 shadow_count = 0;
    list_reply_t        awaited_replies [$];
    int                 failures = 0;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // applies one operation to the shadow list and returns the reply it must produce
    function automatic list_reply_t list_op_outcome(input logic [OPCODE_W-1:0]   op,
                                                    input logic [POSITION_W-1:0] pos,
                                                    input logic [VALUE_W-1:0]    val);
        list_reply_t r;
        int          p;
        int          k;
        r        = '0;
        r.status = STAT_BAD;
        p        = int'(pos);
        case (op)
            OP_INSERT: begin
                if (p >= 1 && p <= shadow_count + 1 && shadow_count < CAPACITY) begin
                    for (k = shadow_count; k > p - 1; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[p-1] = val;
                    shadow_count++;
                    r.status = STAT_DONE;
                end
            end
            OP_DELETE: begin
                if (p >= 1 && p <= shadow_count) begin
                    r.removed_value = shadow_entries[p-1];
                    for (k = p; k < shadow_count; k++)
                        shadow_entries[k-1] = shadow_entries[k];
                    shadow_count--;
                    r.status = STAT_DONE;
                end
            end
            OP_LOCATE: begin
                r.status = STAT_MISS;
                for (k = 0; k < shadow_count; k++) begin
                    if (r.status == STAT_MISS && shadow_entries[k] == val) begin
                        r.found_index = FOUND_W'(k);
                        r.status      = STAT_DONE;
                    end
                end
            end
            default: ;
        endcase
        r.list_length = LENGTH_W'(shadow_count);
        return r;
    endfunction

    task automatic log_failure(input string what, input list_reply_t want,
                               input list_reply_t seen);
        if (failures < 10)
            $display("%0t: %s: expected status %0d removed %h index %0d length %0d, got status %0d removed %h index %0d length %0d",
                     $realtime, what, want.status, want.removed_value, want.found_index,
                     want.list_length, seen.status, seen.removed_value, seen.found_index,
                     seen.list_length);
        failures++;
    endtask

    always @(posedge aclk) begin
        list_reply_t seen;
        list_reply_t want;
        if (!aresetn) begin
            awaited_replies.delete();
            shadow_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.status        = m_tdata[0 +: STATUS_W];
                seen.removed_value = m_tdata[REMOVED_LSB +: VALUE_W];
                seen.found_index   = m_tdata[FOUND_LSB +: FOUND_W];
                seen.list_length   = m_tdata[LENGTH_LSB +: LENGTH_W];
                if (awaited_replies.size() == 0) begin
                    log_failure("result beat with nothing awaited", '0, seen);
                end else begin
                    want = awaited_replies.pop_front();
                    if (seen.status != want.status || seen.removed_value != want.removed_value ||
                        seen.found_index != want.found_index ||
                        seen.list_length != want.list_length)
                        log_failure("result beat mismatch", want, seen);
                end
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(list_op_outcome(s_tdata[0 +: OPCODE_W],
                                                          s_tdata[POS_LSB +: POSITION_W],
                                                          s_tdata[VAL_LSB +: VALUE_W]));
        end
        fail_count  <= failures;
        outstanding <= awaited_replies.size();
    end

endmodule

[tb/sequential_list_engine_core_tb.sv]
// testbench top for the list engine: drives insert, delete and locate beats and gives the verdict
`timescale 1ns / 1ps
module sequential_list_engine_core_tb;
    import sle_pkg::*;

    localparam int          CAPACITY     = CAPACITY_DEF;
    localparam int          RANDOM_ITEMS = 1550;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // opcode, position, value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // status, removed_value, found_index, list_length

    int fail_count;
    int outstanding;
    int cycle_count   = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int list_len      = 0;
    bit grow_list     = 1'b1;

    sequential_list_engine_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sequential_list_engine_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic offer_op(input logic [OPCODE_W-1:0] op, input logic [POSITION_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, pos, op});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // track the length so that positions can be aimed at the live list
        if (op == OP_INSERT && pos >= 1 && int'(pos) <= list_len + 1 && list_len < CAPACITY)
            list_len++;
        else if (op == OP_DELETE && pos >= 1 && int'(pos) <= list_len)
            list_len--;
    endtask

    // small values repeat often so that locates hit and duplicates appear
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return VALUE_W'($urandom_range(15));
        if (roll < 50) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return '1;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic offer_random_op();
        int                    roll;
        int                    bound;
        logic [OPCODE_W-1:0]   op;
        logic [POSITION_W-1:0] pos;
        if (grow_list && list_len == CAPACITY && $urandom_range(3) == 0)
            grow_list = 1'b0;
        else if (!grow_list && list_len == 0 && $urandom_range(3) == 0)
            grow_list = 1'b1;
        roll = $urandom_range(99);
        if (roll < 3)
            op = OP_UNUSED;
        else if (roll < 15)
            op = OP_LOCATE;
        else if (roll < (grow_list ? 85 : 30))
            op = OP_INSERT;
        else
            op = OP_DELETE;
        bound = (op == OP_INSERT) ? list_len + 1 : list_len;
        roll  = $urandom_range(99);
        if (op == OP_LOCATE || op == OP_UNUSED || roll < 5)
            pos = POSITION_W'($urandom_range(255));
        else if (roll < 10)
            pos = '0;
        else if (roll < 15)
            pos = POSITION_W'((bound < 255) ? bound + 1 : 255);
        else if (roll < 25)
            pos = POSITION_W'(bound);
        else if (roll < 35)
            pos = 1;
        else
            pos = POSITION_W'($urandom_range((bound > 0) ? bound : 1, 1));
        offer_op(op, pos, pick_value());
    endtask

    initial begin
        int phase;
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list: locate miss, delete refused, insert outside the valid range
        offer_op(OP_LOCATE, 0, 32'd5);
        offer_op(OP_DELETE, 1, 32'd0);
        offer_op(OP_INSERT, 0, 32'd1);
        offer_op(OP_INSERT, 2, 32'd1);
        // build a list with extremes, a duplicate, front, middle and tail inserts
        offer_op(OP_INSERT, 1, 32'h8000_0000);
        offer_op(OP_INSERT, 2, 32'h7fff_ffff);
        offer_op(OP_INSERT, 1, 32'h0000_0000);
        offer_op(OP_INSERT, 4, 32'hffff_ffff);
        offer_op(OP_INSERT, 2, 32'd7);
        offer_op(OP_INSERT, 6, 32'd7);
        offer_op(OP_INSERT, 255, 32'd3);
        offer_op(OP_INSERT, 8, 32'd3);
        // first match wins among duplicates
        offer_op(OP_LOCATE, 0, 32'd7);
        offer_op(OP_LOCATE, 200, 32'h7fff_ffff);
        offer_op(OP_LOCATE, 9, 32'h0000_0000);
        offer_op(OP_LOCATE, 0, 32'd12345);
        offer_op(OP_UNUSED, 1, 32'hffff_ffff);
        offer_op(OP_DELETE, 0, 32'd0);
        offer_op(OP_DELETE, 7, 32'd0);
        offer_op(OP_DELETE, 6, 32'd0);
        offer_op(OP_DELETE, 1, 32'hffff_ffff);
        offer_op(OP_DELETE, 2, 32'd0);
        offer_op(OP_LOCATE, 0, 32'h7fff_ffff);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct  = 63;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 63;
                end
                default: begin
                    tx_idle_pct  = 14;
                    rx_stall_pct <= 14;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
                // long receiver hold-off while beats keep coming
                if (phase == 0 && n == 100)
                    hold_requests <= hold_requests + 1;
                offer_random_op();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (CAPACITY + 16) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
